@@ src/ordered_slot_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// ordered_slot_allocator assertion macros
// Shared concurrent assertion forms, clocked on clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SLOT_ALLOCATOR_DEFINES_SVH
`define ORDERED_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define OSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/osa_pkg.sv @@
// ----------------------------------------------------------------------------
// osa_pkg
// Types and constants of the ordered slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package osa_pkg;

    localparam int SLOT_W  = 12;
    localparam int COUNT_W = 13;
    localparam int OFF_W   = 24;
    localparam int CB_W    = 16;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int PROD_W  = 32;

    localparam logic [OFF_W-1:0]  OFF_MAX  = 24'hFFFFFF;
    localparam logic [CB_W-1:0]   CB_RESET = 16'd64;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAIN,
        ST_PREV,
        ST_NEXT,
        ST_COMMIT,
        ST_DONE
    } osa_state_t;

    typedef enum logic [1:0] {
        OFF_IDLE,
        OFF_DIV,
        OFF_SUB,
        OFF_MUL
    } osa_off_state_t;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot_in;
    } osa_req_t;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot_out;
        logic               prev_valid;
        logic [SLOT_W-1:0]  prev_slot;
        logic               next_valid;
        logic [SLOT_W-1:0]  next_slot;
        logic [SLOT_W-1:0]  lowest_used;
        logic               is_empty;
        logic [COUNT_W-1:0] used_total;
        logic [OFF_W-1:0]   byte_offset;
    } osa_rsp_t;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ src/osa_req_if.sv @@
// ----------------------------------------------------------------------------
// osa_req_if
// Request channel: valid/ready handshake with an allocate or free request.
// ----------------------------------------------------------------------------
`default_nettype none

interface osa_req_if;
    logic              valid;
    logic              ready;
    osa_pkg::osa_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/osa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// osa_rsp_if
// Response channel: valid/ready handshake with one allocator result.
// ----------------------------------------------------------------------------
`default_nettype none

interface osa_rsp_if;
    logic              valid;
    logic              ready;
    osa_pkg::osa_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/osa_offset.sv @@
// ----------------------------------------------------------------------------
// osa_offset
// Byte offset unit: slot mod CHUNKS_PER_POOL by reciprocal multiplication,
// then one multiply by chunk_bytes with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module osa_offset #(
    parameter int CHUNKS_PER_POOL = 256,
    parameter int SW              = 12
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [SW-1:0]               slot,
    input  wire logic [osa_pkg::CB_W-1:0]    chunk_bytes,
    output logic                             busy,
    output logic [osa_pkg::OFF_W-1:0]        offset
);

    localparam int RS  = SW + $clog2(CHUNKS_PER_POOL);
    localparam int RMW = SW + 2;
    localparam int PW  = SW + RMW;
    localparam logic [RMW-1:0] RECIP =
        RMW'((longint'(1) << RS) / longint'(CHUNKS_PER_POOL) + longint'(1));
    localparam logic [SW-1:0] CPP_C = SW'(CHUNKS_PER_POOL);

    osa_pkg::osa_off_state_t state_reg, state_next;

    logic [SW-1:0]               slot_lat_reg;
    logic [SW-1:0]               q_reg;
    logic [SW-1:0]               rem_reg;
    logic [osa_pkg::PROD_W-1:0]  prod_reg;
    logic [PW-1:0]               recip_prod;
    logic [osa_pkg::CB_W-1:0]    idx;

    assign recip_prod = PW'(slot_lat_reg) * PW'(RECIP);
    assign idx        = osa_pkg::CB_W'(rem_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            osa_pkg::OFF_IDLE:
            begin
                if (start)
                begin
                    state_next = osa_pkg::OFF_DIV;
                end
            end
            osa_pkg::OFF_DIV:
            begin
                state_next = osa_pkg::OFF_SUB;
            end
            osa_pkg::OFF_SUB:
            begin
                state_next = osa_pkg::OFF_MUL;
            end
            osa_pkg::OFF_MUL:
            begin
                state_next = osa_pkg::OFF_IDLE;
            end
            default:
            begin
                state_next = osa_pkg::OFF_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != osa_pkg::OFF_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= osa_pkg::OFF_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            osa_pkg::OFF_IDLE:
            begin
                if (start)
                begin
                    slot_lat_reg <= slot;
                end
            end
            osa_pkg::OFF_DIV:
            begin
                q_reg <= SW'(recip_prod >> RS);
            end
            osa_pkg::OFF_SUB:
            begin
                rem_reg <= slot_lat_reg - q_reg * CPP_C;
            end
            osa_pkg::OFF_MUL:
            begin
                prod_reg <= osa_pkg::PROD_W'(idx) * osa_pkg::PROD_W'(chunk_bytes);
            end
            default:
            begin
            end
        endcase
    end

    assign offset = (prod_reg > osa_pkg::PROD_W'(osa_pkg::OFF_MAX))
                  ? osa_pkg::OFF_MAX : prod_reg[osa_pkg::OFF_W-1:0];

endmodule

`default_nettype wire

@@ src/ordered_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// ordered_slot_allocator
// Lowest-free-slot chunk allocator with ordered used neighbours.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | mode, slot_in
//  rsp     | out | valid/ready | ok, slot, neighbours, lowest, count, offset
//  cfg     | in  | cfg_we      | chunk_bytes
//
//  One request at a time: accept, word read, 0-2 neighbour word reads,
//  commit, then the offset unit; the done state waits for its result.
//  No new request is accepted until the result is loaded. Failed
//  requests skip the commit and the offset unit.
//  Reset clears per-word used/full flags at once; no clearing pass.
//  A waiting response holds the next result until rsp.ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_slot_allocator_defines.svh"

module ordered_slot_allocator #(
    parameter int POOL_COUNT      = 16,
    parameter int CHUNKS_PER_POOL = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [osa_pkg::CB_W-1:0] cfg_wdata,
    osa_req_if.sink                       req,
    osa_rsp_if.source                     rsp
);

    localparam int SLOT_TOTAL = POOL_COUNT * CHUNKS_PER_POOL;
    localparam int WW         = osa_pkg::WORD_W;
    localparam int BW         = osa_pkg::BIT_W;
    localparam int WORDS      = (SLOT_TOTAL + WW - 1) / WW;
    localparam int WI_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW         = WI_W + BW;
    localparam int CNT_W      = $clog2(SLOT_TOTAL + 1);
    localparam int TAIL       = SLOT_TOTAL % WW;
    localparam logic [WW-1:0] TAIL_MASK = (TAIL == 0) ? {WW{1'b1}}
                                        : ((WW'(1) << TAIL) - WW'(1));

    osa_pkg::osa_state_t state_reg, state_next;

    logic [WW-1:0]    mem [WORDS];
    logic [WW-1:0]    rd_data_reg;
    logic             rd_any_reg;
    logic [WW-1:0]    rd_word;
    logic             rd_en;
    logic [WI_W-1:0]  rd_addr;
    logic             wr_en;

    logic [WORDS-1:0] any_reg;
    logic [WORDS-1:0] full_reg;

    logic                       mode_reg;
    logic [osa_pkg::SLOT_W-1:0] req_slot_reg;
    logic [SW-1:0]              slot_reg;
    logic                       ok_reg;
    logic                       pv_valid_reg;
    logic [SW-1:0]              pv_reg;
    logic                       nx_valid_reg;
    logic [SW-1:0]              nx_reg;
    logic [WI_W-1:0]            lo_word_reg;
    logic [WI_W-1:0]            up_word_reg;
    logic                       need_next_reg;
    logic [WW-1:0]              word_reg;
    logic                       first_valid_reg;
    logic [SW-1:0]              first_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [osa_pkg::CB_W-1:0]   cb_reg;

    osa_pkg::osa_rsp_t rsp_reg;
    logic              rsp_valid_reg;

    logic             req_fire;
    logic             in_range;
    logic [SW-1:0]    req_slot_ext;
    logic             free_found;
    logic [WI_W-1:0]  free_word;
    logic [WI_W-1:0]  cur_word;
    logic [BW-1:0]    cur_bit;
    logic [WW-1:0]    below;
    logic [WW-1:0]    above;
    logic             lo_found;
    logic [WI_W-1:0]  lo_word;
    logic             up_found;
    logic [WI_W-1:0]  up_word;
    logic             main_ok;
    logic [WW-1:0]    new_word;
    logic [WW-1:0]    cur_mask;
    logic             off_start;
    logic             off_busy;
    logic [osa_pkg::OFF_W-1:0] off_value;
    logic             rsp_room;
    logic             load_rsp;

    assign req_fire     = req.valid && req.ready;
    assign in_range     = 32'(req.data.slot_in) < 32'(SLOT_TOTAL);
    assign req_slot_ext = SW'(req.data.slot_in);
    assign rd_word      = rd_any_reg ? rd_data_reg : '0;
    assign cur_word     = slot_reg[SW-1:BW];
    assign cur_mask     = (32'(cur_word) == WORDS - 1) ? TAIL_MASK : {WW{1'b1}};
    assign cur_bit      = (mode_reg == osa_pkg::MODE_ALLOC)
                        ? osa_pkg::lowest_set(~(rd_word | ~cur_mask))
                        : slot_reg[BW-1:0];
    assign below        = rd_word & ((WW'(1) << cur_bit) - WW'(1));
    assign above        = rd_word & ~((WW'(2) << cur_bit) - WW'(1));
    assign main_ok      = (mode_reg == osa_pkg::MODE_ALLOC) || rd_word[cur_bit];
    assign new_word     = word_reg ^ (WW'(1) << slot_reg[BW-1:0]);
    assign rsp_room     = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        free_found = 1'b0;
        free_word  = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                free_found = 1'b1;
                free_word  = WI_W'(i);
            end
        end
    end

    always_comb
    begin
        lo_found = 1'b0;
        lo_word  = '0;
        for (int i = 0; i < WORDS; i++)
        begin
            if (any_reg[i] && (WI_W'(i) < cur_word))
            begin
                lo_found = 1'b1;
                lo_word  = WI_W'(i);
            end
        end
    end

    always_comb
    begin
        up_found = 1'b0;
        up_word  = '0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (any_reg[i] && (WI_W'(i) > cur_word))
            begin
                up_found = 1'b1;
                up_word  = WI_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            osa_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.mode == osa_pkg::MODE_ALLOC)
                    begin
                        state_next = free_found ? osa_pkg::ST_MAIN : osa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = in_range ? osa_pkg::ST_MAIN : osa_pkg::ST_DONE;
                    end
                end
            end
            osa_pkg::ST_MAIN:
            begin
                priority if (!main_ok)
                begin
                    state_next = osa_pkg::ST_DONE;
                end
                else if (!(|below) && lo_found)
                begin
                    state_next = osa_pkg::ST_PREV;
                end
                else if (!(|above) && up_found)
                begin
                    state_next = osa_pkg::ST_NEXT;
                end
                else
                begin
                    state_next = osa_pkg::ST_COMMIT;
                end
            end
            osa_pkg::ST_PREV:
            begin
                state_next = need_next_reg ? osa_pkg::ST_NEXT : osa_pkg::ST_COMMIT;
            end
            osa_pkg::ST_NEXT:
            begin
                state_next = osa_pkg::ST_COMMIT;
            end
            osa_pkg::ST_COMMIT:
            begin
                state_next = osa_pkg::ST_DONE;
            end
            osa_pkg::ST_DONE:
            begin
                if (rsp_room && !off_busy)
                begin
                    state_next = osa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = osa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        off_start = 1'b0;
        load_rsp  = 1'b0;
        req.ready = 1'b0;
        unique case (state_reg)
            osa_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                rd_en     = req.valid;
                rd_addr   = (req.data.mode == osa_pkg::MODE_ALLOC)
                          ? free_word : req_slot_ext[SW-1:BW];
            end
            osa_pkg::ST_MAIN:
            begin
                rd_en   = main_ok;
                rd_addr = (!(|below) && lo_found) ? lo_word : up_word;
            end
            osa_pkg::ST_PREV:
            begin
                rd_en   = need_next_reg;
                rd_addr = up_word_reg;
            end
            osa_pkg::ST_NEXT:
            begin
            end
            osa_pkg::ST_COMMIT:
            begin
                wr_en     = 1'b1;
                off_start = 1'b1;
            end
            osa_pkg::ST_DONE:
            begin
                load_rsp = rsp_room && !off_busy;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_word] <= new_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_any_reg  <= any_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= osa_pkg::ST_IDLE;
            any_reg         <= '0;
            full_reg        <= '0;
            first_valid_reg <= 1'b0;
            count_reg       <= '0;
            cb_reg          <= osa_pkg::CB_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cb_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                any_reg[cur_word]  <= |new_word;
                full_reg[cur_word] <= &(new_word | ~cur_mask);
                if (mode_reg == osa_pkg::MODE_ALLOC)
                begin
                    count_reg <= count_reg + 1'b1;
                    if (!first_valid_reg || (slot_reg < first_reg))
                    begin
                        first_valid_reg <= 1'b1;
                    end
                end
                else
                begin
                    count_reg <= count_reg - 1'b1;
                    if (first_valid_reg && (first_reg == slot_reg))
                    begin
                        first_valid_reg <= nx_valid_reg;
                    end
                end
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mode_reg     <= req.data.mode;
            req_slot_reg <= req.data.slot_in;
            ok_reg       <= 1'b0;
            slot_reg     <= (req.data.mode == osa_pkg::MODE_ALLOC)
                          ? {free_word, {BW{1'b0}}} : req_slot_ext;
        end
        if (state_reg == osa_pkg::ST_MAIN)
        begin
            ok_reg        <= main_ok;
            slot_reg      <= {cur_word, cur_bit};
            word_reg      <= rd_word;
            pv_valid_reg  <= |below;
            pv_reg        <= {cur_word, osa_pkg::highest_set(below)};
            nx_valid_reg  <= |above;
            nx_reg        <= {cur_word, osa_pkg::lowest_set(above)};
            lo_word_reg   <= lo_word;
            up_word_reg   <= up_word;
            need_next_reg <= !(|above) && up_found;
        end
        if (state_reg == osa_pkg::ST_PREV)
        begin
            pv_valid_reg <= 1'b1;
            pv_reg       <= {lo_word_reg, osa_pkg::highest_set(rd_word)};
        end
        if (state_reg == osa_pkg::ST_NEXT)
        begin
            nx_valid_reg <= 1'b1;
            nx_reg       <= {up_word_reg, osa_pkg::lowest_set(rd_word)};
        end
        if (wr_en)
        begin
            if (mode_reg == osa_pkg::MODE_ALLOC)
            begin
                if (!first_valid_reg || (slot_reg < first_reg))
                begin
                    first_reg <= slot_reg;
                end
            end
            else if (first_valid_reg && (first_reg == slot_reg))
            begin
                first_reg <= nx_reg;
            end
        end
        if (load_rsp)
        begin
            rsp_reg.ok          <= ok_reg;
            rsp_reg.slot_out    <= ok_reg ? osa_pkg::SLOT_W'(slot_reg)
                                 : ((mode_reg == osa_pkg::MODE_FREE) ? req_slot_reg : '0);
            rsp_reg.prev_valid  <= ok_reg && pv_valid_reg;
            rsp_reg.prev_slot   <= (ok_reg && pv_valid_reg) ? osa_pkg::SLOT_W'(pv_reg) : '0;
            rsp_reg.next_valid  <= ok_reg && nx_valid_reg;
            rsp_reg.next_slot   <= (ok_reg && nx_valid_reg) ? osa_pkg::SLOT_W'(nx_reg) : '0;
            rsp_reg.lowest_used <= first_valid_reg ? osa_pkg::SLOT_W'(first_reg) : '0;
            rsp_reg.is_empty    <= !first_valid_reg;
            rsp_reg.used_total  <= osa_pkg::COUNT_W'(count_reg);
            rsp_reg.byte_offset <= ok_reg ? off_value : '0;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    osa_offset #(
        .CHUNKS_PER_POOL (CHUNKS_PER_POOL),
        .SW              (SW)
    ) u_offset (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (off_start),
        .slot        (slot_reg),
        .chunk_bytes (cb_reg),
        .busy        (off_busy),
        .offset      (off_value)
    );

    `OSA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(SLOT_TOTAL),
        "used count above slot total")
    `OSA_ASSERT_IMP(a_first_matches_count, clk, rst_n, 1'b1,
        first_valid_reg == (count_reg != '0), "lowest used flag disagrees with count")
    `OSA_ASSERT_IMP(a_commit_bit, clk, rst_n, wr_en,
        word_reg[slot_reg[BW-1:0]] == (mode_reg == osa_pkg::MODE_FREE),
        "commit toggles a slot in the wrong state")
    `OSA_ASSERT_IMP(a_prev_nonempty, clk, rst_n, rsp.valid && rsp.data.prev_valid,
        !rsp.data.is_empty, "neighbour reported while empty")
    `OSA_ASSERT_NXT(a_commit_done, clk, rst_n, wr_en,
        (state_reg == osa_pkg::ST_DONE) && off_busy, "offset unit not started at commit")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered slot allocator: a driver sends
// allocate and free requests, a monitor compares every result with a model
// of the used map, the ordered neighbours, the count and the byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 4096;
    localparam int CPP   = 256;
    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [osa_pkg::CB_W-1:0] cfg_wdata = '0;

    osa_req_if req ();
    osa_rsp_if rsp ();

    ordered_slot_allocator dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .req(req), .rsp(rsp)
    );

    always #5 clk = ~clk;

    bit                 used_map [SLOTS];
    int                 used_cnt;
    int                 chunk_sz;
    osa_pkg::osa_req_t  pending_reqs [$];
    osa_pkg::osa_rsp_t  expected_rsps [$];
    int                 errors;
    int                 cycles;
    int                 gap_left;
    bit                 hold_sender;

    function automatic osa_pkg::osa_rsp_t predict_request(osa_pkg::osa_req_t r);
        osa_pkg::osa_rsp_t o;
        int s;
        int lo;
        longint off;
        o = '0;
        s = -1;
        if (r.mode == osa_pkg::MODE_ALLOC)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!used_map[i])
                begin
                    s = i;
                    break;
                end
            end
        end
        else
        begin
            o.slot_out = r.slot_in;
            if (used_map[r.slot_in])
                s = r.slot_in;
        end
        if (s >= 0)
        begin
            o.ok = 1'b1;
            o.slot_out = osa_pkg::SLOT_W'(s);
            for (int i = s - 1; i >= 0; i--)
            begin
                if (used_map[i])
                begin
                    o.prev_valid = 1'b1;
                    o.prev_slot = osa_pkg::SLOT_W'(i);
                    break;
                end
            end
            for (int i = s + 1; i < SLOTS; i++)
            begin
                if (used_map[i])
                begin
                    o.next_valid = 1'b1;
                    o.next_slot = osa_pkg::SLOT_W'(i);
                    break;
                end
            end
            used_map[s] = (r.mode == osa_pkg::MODE_ALLOC);
            used_cnt += (r.mode == osa_pkg::MODE_ALLOC) ? 1 : -1;
            off = longint'(s % CPP) * chunk_sz;
            o.byte_offset = (off > osa_pkg::OFF_MAX) ? osa_pkg::OFF_MAX
                                                     : osa_pkg::OFF_W'(off);
        end
        lo = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (used_map[i])
            begin
                lo = i;
                break;
            end
        end
        o.lowest_used = (lo < 0) ? '0 : osa_pkg::SLOT_W'(lo);
        o.is_empty = (lo < 0);
        o.used_total = osa_pkg::COUNT_W'(used_cnt);
        return o;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 4)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data  <= '0;
            gap_left  <= 0;
        end
        else if (req.valid && !req.ready)
        begin
        end
        else if (gap_left > 0)
        begin
            req.valid <= 1'b0;
            gap_left  <= gap_left - 1;
        end
        else if (pending_reqs.size() > 0 && !hold_sender)
        begin
            req.valid <= 1'b1;
            req.data  <= pending_reqs.pop_front();
            gap_left  <= pick_gap();
        end
        else
            req.valid <= 1'b0;
    end

    // prediction at acceptance
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            expected_rsps.push_back(predict_request(req.data));
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        osa_pkg::osa_rsp_t want;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t unexpected result %p", $time, rsp.data);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.data !== want)
                    begin
                        $display("%0t mismatch expected %p actual %p",
                                 $time, want, rsp.data);
                        errors++;
                    end
                end
            end
            rsp.ready <= (pick_gap() == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL ordered_slot_allocator");
            $finish;
        end
    end

    task automatic add_req(logic m, int s);
        osa_pkg::osa_req_t r;
        r.mode = m;
        r.slot_in = osa_pkg::SLOT_W'(s);
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_chunk(int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= osa_pkg::CB_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        chunk_sz = v;
    endtask

    initial
    begin
        int live [$];
        int k;
        errors = 0;
        cycles = 0;
        used_cnt = 0;
        chunk_sz = 64;
        hold_sender = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty free, high free, fills, holes, edges
        add_req(osa_pkg::MODE_FREE, 0);
        add_req(osa_pkg::MODE_FREE, 4095);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_FREE, 1);
        add_req(osa_pkg::MODE_FREE, 1);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_FREE, 0);
        add_req(osa_pkg::MODE_FREE, 2);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_FREE, 3);
        add_req(osa_pkg::MODE_FREE, 2);
        add_req(osa_pkg::MODE_FREE, 1);
        add_req(osa_pkg::MODE_FREE, 0);
        drain();

        // fill across several map words, punch holes, refill
        write_chunk(65535);
        for (int i = 0; i < 120; i++)
            add_req(osa_pkg::MODE_ALLOC, $urandom_range(0, 4095));
        add_req(osa_pkg::MODE_FREE, 4095);
        add_req(osa_pkg::MODE_FREE, 100);
        add_req(osa_pkg::MODE_FREE, 63);
        add_req(osa_pkg::MODE_FREE, 64);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        add_req(osa_pkg::MODE_ALLOC, 0);
        for (int i = 0; i < 128; i += 4)
            add_req(osa_pkg::MODE_FREE, i);
        drain();
        for (int i = 1; i < 128; i += 4)
            add_req(osa_pkg::MODE_FREE, i);

        // pause the sender mid-stream until every result is back
        repeat (60) @(posedge clk);
        hold_sender = 1;
        while (req.valid || expected_rsps.size() > 0)
            @(posedge clk);
        hold_sender = 0;
        drain();

        // random phases over several chunk sizes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_chunk(1);
                1: write_chunk($urandom_range(2, 65534));
                2: write_chunk(0);
                default: write_chunk(65535);
            endcase
            live.delete();
            for (int i = 0; i < SLOTS; i++)
                if (used_map[i])
                    live.push_back(i);
            for (int n = 0; n < 75; n++)
            begin
                k = $urandom_range(0, 9);
                if (k < 5 || live.size() == 0)
                begin
                    add_req(osa_pkg::MODE_ALLOC, $urandom_range(0, 4095));
                end
                else if (k < 9)
                begin
                    k = $urandom_range(0, live.size() - 1);
                    add_req(osa_pkg::MODE_FREE, live[k]);
                    live.delete(k);
                end
                else
                    add_req(osa_pkg::MODE_FREE, $urandom_range(0, 4095));
            end
            drain();
        end

        if (errors == 0)
            $display("PASS ordered_slot_allocator");
        else
            $display("FAIL ordered_slot_allocator");
        $finish;
    end
endmodule

`default_nettype wire

@@ ordered_slot_allocator.f @@
+incdir+src
src/osa_pkg.sv
src/osa_req_if.sv
src/osa_rsp_if.sv
src/osa_offset.sv
src/ordered_slot_allocator.sv
bench/tb.sv
